/* src/enc_vel_pkg.sv */
// ----------------------------------------------------------------------------
// enc_vel_pkg
// Types, constants and small helpers for the encoder velocity estimator.
// ----------------------------------------------------------------------------
package enc_vel_pkg;

  localparam int NUM_AXES = 2;
  localparam int AXIS_W   = 1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_PULSE_TIMER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIM_AXIS_MASK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SHIFT0   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SHIFT1   = 2'd3;

  localparam logic [31:0] DELTA_LIMIT = 32'd6;
  localparam logic [31:0] PULSE_LIMIT = 32'd128;
  localparam logic [12:0] HOLD_NUMER  = 13'd4096;
  localparam logic [3:0]  VEL_SHIFT   = 4'd4;
  localparam logic [3:0]  PULSE_SHIFT = 4'd8;
  localparam logic [3:0]  REF_SHIFT   = 4'd4;
  localparam logic [2:0]  DIV_STEPS_M1 = 3'd4;

  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;
  localparam logic [1:0] DIR_STOP = 2'b00;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    BR_DELTA,
    BR_PULSE,
    BR_HOLD,
    BR_STOP
  } branch_t;

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [1:0] sign_of(input logic [31:0] v, input logic [1:0] keep);
    if (v == 32'd0) begin
      return keep;
    end
    return v[31] ? DIR_REV : DIR_FWD;
  endfunction

  function automatic logic [31:0] div_pow2(input logic [31:0] v, input logic [3:0] k);
    logic [31:0] q;
    q = magnitude(v) >> k;
    return v[31] ? (32'd0 - q) : q;
  endfunction

endpackage

/* src/encoder_velocity_estimator.sv */
// ----------------------------------------------------------------------------
// encoder_velocity_estimator
// Per-axis velocity estimate from encoder count delta or pulse-width speed.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one control tick of one axis:
//   its encoder count, pulse-width speed, init flag and reference velocity.
//   Output channel (out_valid/out_ready) returns one item per tick: axis,
//   velocity, raw delta, direction and the shifted position count.
//   Configuration is to be written through cfg_we/cfg_index/cfg_wdata
//   only while idle; the block itself does not enforce this. An item goes
//   through S_EVAL, then S_DIV when the pulse-width speed is used, to S_OUT:
//   the hold count 4096/|speed| comes from a shared compare-subtract unit
//   resolving one quotient bit per cycle. in_ready is high only while no
//   item is in work: a new item is taken after the last one is committed.
//   A finished item waits in the output register; the next item is taken
//   and worked meanwhile and then waits until the output register frees.
//   Synchronous reset clears configuration and all per-axis state to zero.
// ----------------------------------------------------------------------------
module encoder_velocity_estimator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_axis,
  input  logic        [31:0]                  in_encoder_count,
  input  logic signed [31:0]                  in_pulse_speed,
  input  logic                                in_init_request,
  input  logic signed [31:0]                  in_reference_velocity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_axis_out,
  output logic signed [31:0]                  out_velocity,
  output logic signed [31:0]                  out_raw_delta,
  output logic signed [1:0]                   out_direction,
  output logic        [31:0]                  out_scaled_count,
  input  logic                                cfg_we,
  input  logic [enc_vel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [enc_vel_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  enc_vel_pkg::state_t  state_r, state_nxt;
  enc_vel_pkg::branch_t branch_r, branch_nxt;

  logic        no_pulse_r;
  logic [1:0]  sim_mask_r;
  logic [4:0]  shift0_r;
  logic [4:0]  shift1_r;

  logic [31:0] prev_count_r [enc_vel_pkg::NUM_AXES];
  logic [4:0]  hold_r       [enc_vel_pkg::NUM_AXES];
  logic [31:0] last_vel_r   [enc_vel_pkg::NUM_AXES];
  logic [1:0]  last_dir_r   [enc_vel_pkg::NUM_AXES];
  logic [31:0] sim_count_r  [enc_vel_pkg::NUM_AXES];

  logic [enc_vel_pkg::AXIS_W-1:0] ax_r;
  logic [31:0] count_r;
  logic [31:0] spd_r;
  logic        init_r;
  logic [31:0] ref_r;

  logic [31:0] delta_r, delta_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [4:0]  quot_r, quot_nxt;
  logic [2:0]  step_r, step_nxt;

  logic        out_valid_r;
  logic        out_axis_r;
  logic [31:0] out_vel_r;
  logic [31:0] out_raw_r;
  logic [1:0]  out_dir_r;
  logic [31:0] out_scaled_r;

  logic [36:0] trial;
  logic        fits;
  logic        commit;
  logic [31:0] mag_delta;

  logic [31:0] vel_c;
  logic [31:0] raw_c;
  logic [1:0]  dir_c;
  logic [4:0]  hold_c;
  logic [31:0] stored_c;
  logic [31:0] sim_c;
  logic        sim_en;
  logic [4:0]  shift_c;

  assign in_ready         = (state_r == enc_vel_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_axis_out     = out_axis_r;
  assign out_velocity     = $signed(out_vel_r);
  assign out_raw_delta    = $signed(out_raw_r);
  assign out_direction    = $signed(out_dir_r);
  assign out_scaled_count = out_scaled_r;

  // shared compare-subtract unit
  assign trial = {5'd0, mag_r} << step_r;
  assign fits  = (trial <= {24'd0, rem_r});

  assign commit = (state_r == enc_vel_pkg::S_OUT) && (!out_valid_r || out_ready);

  assign mag_delta = enc_vel_pkg::magnitude(count_r - prev_count_r[ax_r]);

  always_comb begin
    state_nxt  = state_r;
    branch_nxt = branch_r;
    delta_nxt  = delta_r;
    mag_nxt    = mag_r;
    rem_nxt    = rem_r;
    quot_nxt   = quot_r;
    step_nxt   = step_r;
    unique case (state_r)
      enc_vel_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = enc_vel_pkg::S_EVAL;
        end
      end
      enc_vel_pkg::S_EVAL: begin
        delta_nxt = count_r - prev_count_r[ax_r];
        mag_nxt   = enc_vel_pkg::magnitude(spd_r);
        rem_nxt   = enc_vel_pkg::HOLD_NUMER;
        quot_nxt  = 5'd0;
        step_nxt  = enc_vel_pkg::DIV_STEPS_M1;
        if (mag_delta > enc_vel_pkg::DELTA_LIMIT || no_pulse_r) begin
          branch_nxt = enc_vel_pkg::BR_DELTA;
          state_nxt  = enc_vel_pkg::S_OUT;
        end else if (enc_vel_pkg::magnitude(spd_r) > enc_vel_pkg::PULSE_LIMIT) begin
          branch_nxt = enc_vel_pkg::BR_PULSE;
          state_nxt  = enc_vel_pkg::S_DIV;
        end else if (hold_r[ax_r] != 5'd0) begin
          branch_nxt = enc_vel_pkg::BR_HOLD;
          state_nxt  = enc_vel_pkg::S_OUT;
        end else begin
          branch_nxt = enc_vel_pkg::BR_STOP;
          state_nxt  = enc_vel_pkg::S_OUT;
        end
      end
      enc_vel_pkg::S_DIV: begin
        quot_nxt = {quot_r[3:0], fits};
        if (fits) begin
          rem_nxt = rem_r - trial[12:0];
        end
        if (step_r == 3'd0) begin
          state_nxt = enc_vel_pkg::S_OUT;
        end else begin
          step_nxt = step_r - 3'd1;
        end
      end
      enc_vel_pkg::S_OUT: begin
        if (commit) begin
          state_nxt = enc_vel_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = enc_vel_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    vel_c    = 32'd0;
    dir_c    = enc_vel_pkg::DIR_STOP;
    hold_c   = hold_r[ax_r];
    case (branch_r)
      enc_vel_pkg::BR_DELTA: begin
        vel_c  = delta_r << enc_vel_pkg::VEL_SHIFT;
        hold_c = 5'd0;
        dir_c  = enc_vel_pkg::sign_of(delta_r << enc_vel_pkg::VEL_SHIFT, last_dir_r[ax_r]);
      end
      enc_vel_pkg::BR_PULSE: begin
        vel_c  = enc_vel_pkg::div_pow2(spd_r, enc_vel_pkg::PULSE_SHIFT);
        hold_c = quot_r;
        dir_c  = enc_vel_pkg::sign_of(enc_vel_pkg::div_pow2(spd_r, enc_vel_pkg::PULSE_SHIFT),
                                      last_dir_r[ax_r]);
      end
      enc_vel_pkg::BR_HOLD: begin
        vel_c  = last_vel_r[ax_r];
        hold_c = hold_r[ax_r] - 5'd1;
        dir_c  = last_dir_r[ax_r];
      end
      default: begin
        vel_c = 32'd0;
        dir_c = enc_vel_pkg::DIR_STOP;
      end
    endcase
    if (init_r) begin
      vel_c = 32'd0;
      dir_c = enc_vel_pkg::DIR_STOP;
    end
    sim_en   = sim_mask_r[ax_r];
    raw_c    = delta_r;
    stored_c = count_r;
    sim_c    = sim_count_r[ax_r];
    if (sim_en) begin
      vel_c    = ref_r;
      raw_c    = enc_vel_pkg::div_pow2(ref_r, enc_vel_pkg::REF_SHIFT);
      sim_c    = sim_count_r[ax_r] + enc_vel_pkg::div_pow2(ref_r, enc_vel_pkg::REF_SHIFT);
      stored_c = sim_c;
      dir_c    = enc_vel_pkg::sign_of(ref_r, enc_vel_pkg::DIR_STOP);
    end
    shift_c = ax_r[0] ? shift1_r : shift0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= enc_vel_pkg::S_IDLE;
      branch_r    <= enc_vel_pkg::BR_STOP;
      out_valid_r <= 1'b0;
      no_pulse_r  <= 1'b0;
      sim_mask_r  <= 2'd0;
      shift0_r    <= 5'd0;
      shift1_r    <= 5'd0;
      for (int a = 0; a < enc_vel_pkg::NUM_AXES; a++) begin
        prev_count_r[a] <= 32'd0;
        hold_r[a]       <= 5'd0;
        last_vel_r[a]   <= 32'd0;
        last_dir_r[a]   <= enc_vel_pkg::DIR_STOP;
        sim_count_r[a]  <= 32'd0;
      end
    end else begin
      state_r  <= state_nxt;
      branch_r <= branch_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          enc_vel_pkg::CFG_NO_PULSE_TIMER: no_pulse_r <= cfg_wdata[0];
          enc_vel_pkg::CFG_SIM_AXIS_MASK:  sim_mask_r <= cfg_wdata[1:0];
          enc_vel_pkg::CFG_COUNT_SHIFT0:   shift0_r   <= cfg_wdata;
          enc_vel_pkg::CFG_COUNT_SHIFT1:   shift1_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_r          <= 1'b1;
        prev_count_r[ax_r]   <= stored_c;
        hold_r[ax_r]         <= hold_c;
        last_vel_r[ax_r]     <= vel_c;
        last_dir_r[ax_r]     <= dir_c;
        sim_count_r[ax_r]    <= sim_c;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r    <= in_axis;
      count_r <= in_encoder_count;
      spd_r   <= $unsigned(in_pulse_speed);
      init_r  <= in_init_request;
      ref_r   <= $unsigned(in_reference_velocity);
    end
    delta_r <= delta_nxt;
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    step_r  <= step_nxt;
    if (commit) begin
      out_axis_r   <= ax_r[0];
      out_vel_r    <= vel_c;
      out_raw_r    <= raw_c;
      out_dir_r    <= dir_c;
      out_scaled_r <= stored_c >> shift_c;
    end
  end

`ifndef SYNTH
  a_div_only_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == enc_vel_pkg::S_DIV) |-> (branch_r == enc_vel_pkg::BR_PULSE)
      && (mag_r > enc_vel_pkg::PULSE_LIMIT))
    else $error("divider running outside pulse branch");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == enc_vel_pkg::S_OUT && branch_r == enc_vel_pkg::BR_PULSE)
      |-> ({19'd0, rem_r} < mag_r))
    else $error("hold quotient remainder not below divisor");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == enc_vel_pkg::S_DIV && step_r == 3'd0) |=> (state_r == enc_vel_pkg::S_OUT))
    else $error("divider did not finish after last step");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == enc_vel_pkg::S_EVAL))
    else $error("accepted item not evaluated");

  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == enc_vel_pkg::S_OUT))
    else $error("result appeared without a commit");
`endif

endmodule

/* dv/velocity_checker.sv */
// ----------------------------------------------------------------------------
// velocity_checker
// Watches the tick, result and register ports of the encoder velocity
// estimator. Keeps its own copy of the per-axis state and of the register
// settings, works out the estimate for every accepted tick, and compares
// each accepted result, field by field, against the oldest estimate still
// waiting. Reports the number of waiting estimates and of failures.
// ----------------------------------------------------------------------------
module velocity_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_axis,
  input  logic        [31:0]                  in_encoder_count,
  input  logic signed [31:0]                  in_pulse_speed,
  input  logic                                in_init_request,
  input  logic signed [31:0]                  in_reference_velocity,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                out_axis_out,
  input  logic signed [31:0]                  out_velocity,
  input  logic signed [31:0]                  out_raw_delta,
  input  logic signed [1:0]                   out_direction,
  input  logic        [31:0]                  out_scaled_count,
  input  logic                                cfg_we,
  input  logic [enc_vel_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [enc_vel_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                  pending,
  output int                                  fail_count
);

  localparam logic [31:0] SMALL_DELTA_MAX = 32'd6;
  localparam logic [31:0] SLOW_PULSE_MAX  = 32'd128;
  localparam logic [31:0] HOLD_DIVIDEND   = 32'd4096;

  typedef struct packed {
    logic        axis;
    logic [31:0] count;
    logic [31:0] speed;
    logic        init;
    logic [31:0] ref_vel;
  } tick_t;

  typedef struct packed {
    logic        axis;
    logic [31:0] velocity;
    logic [31:0] raw_delta;
    logic [1:0]  direction;
    logic [31:0] scaled_count;
  } estimate_t;

  logic        no_pulse_timer;
  logic [1:0]  sim_mask;
  logic [4:0]  shift_axis0;
  logic [4:0]  shift_axis1;

  logic [31:0] prev_count [2];
  logic [4:0]  hold_cnt   [2];
  logic [31:0] last_vel   [2];
  logic [1:0]  last_dir   [2];
  logic [31:0] sim_count  [2];

  estimate_t expected_estimates [$];
  int        fails;

  function automatic logic [31:0] abs_val(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [1:0] dir_of(input logic [31:0] v, input logic [1:0] keep);
    if (v == 32'd0) begin
      return keep;
    end
    return v[31] ? enc_vel_pkg::DIR_REV : enc_vel_pkg::DIR_FWD;
  endfunction

  function automatic logic [31:0] trunc_shift(input logic [31:0] v, input int k);
    logic [31:0] q;
    q = abs_val(v) >> k;
    return v[31] ? (~q + 32'd1) : q;
  endfunction

  function automatic estimate_t estimate_velocity(input tick_t t);
    estimate_t   e;
    logic        a;
    logic [31:0] delta;
    logic [31:0] vel;
    logic [31:0] raw;
    logic [31:0] stored;
    logic [31:0] quot;
    logic [1:0]  dir;
    a      = t.axis;
    delta  = t.count - prev_count[a];
    raw    = delta;
    stored = t.count;
    dir    = last_dir[a];
    if (abs_val(delta) > SMALL_DELTA_MAX || no_pulse_timer) begin
      vel         = delta << 4;
      hold_cnt[a] = 5'd0;
      dir         = dir_of(vel, dir);
    end else if (abs_val(t.speed) > SLOW_PULSE_MAX) begin
      quot        = HOLD_DIVIDEND / abs_val(t.speed);
      hold_cnt[a] = quot[4:0];
      vel         = trunc_shift(t.speed, 8);
      dir         = dir_of(vel, dir);
    end else if (hold_cnt[a] != 5'd0) begin
      hold_cnt[a] = hold_cnt[a] - 5'd1;
      vel         = last_vel[a];
    end else begin
      vel = 32'd0;
      dir = enc_vel_pkg::DIR_STOP;
    end
    if (t.init) begin
      vel = 32'd0;
      dir = enc_vel_pkg::DIR_STOP;
    end
    if (sim_mask[a]) begin
      vel          = t.ref_vel;
      raw          = trunc_shift(t.ref_vel, 4);
      sim_count[a] = sim_count[a] + raw;
      stored       = sim_count[a];
      dir          = dir_of(t.ref_vel, enc_vel_pkg::DIR_STOP);
    end
    last_vel[a]   = vel;
    last_dir[a]   = dir;
    prev_count[a] = stored;
    e.axis         = a;
    e.velocity     = vel;
    e.raw_delta    = raw;
    e.direction    = dir;
    e.scaled_count = stored >> (a ? shift_axis1 : shift_axis0);
    return e;
  endfunction

  always @(posedge clk) begin : watch
    tick_t     tick;
    estimate_t want;
    if (!rst_n) begin
      no_pulse_timer = 1'b0;
      sim_mask       = 2'd0;
      shift_axis0    = 5'd0;
      shift_axis1    = 5'd0;
      for (int a = 0; a < 2; a++) begin
        prev_count[a] = 32'd0;
        hold_cnt[a]   = 5'd0;
        last_vel[a]   = 32'd0;
        last_dir[a]   = enc_vel_pkg::DIR_STOP;
        sim_count[a]  = 32'd0;
      end
      expected_estimates.delete();
      fails = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          enc_vel_pkg::CFG_NO_PULSE_TIMER: no_pulse_timer = cfg_wdata[0];
          enc_vel_pkg::CFG_SIM_AXIS_MASK:  sim_mask       = cfg_wdata[1:0];
          enc_vel_pkg::CFG_COUNT_SHIFT0:   shift_axis0    = cfg_wdata[4:0];
          enc_vel_pkg::CFG_COUNT_SHIFT1:   shift_axis1    = cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          $error("result item with no estimate waiting: axis %0d", out_axis_out);
          fails++;
        end else begin
          want = expected_estimates.pop_front();
          if (out_axis_out !== want.axis) begin
            $error("axis_out: expected %0d, got %0d", want.axis, out_axis_out);
            fails++;
          end
          if (out_velocity !== want.velocity) begin
            $error("velocity: expected %0d, got %0d", $signed(want.velocity), out_velocity);
            fails++;
          end
          if (out_raw_delta !== want.raw_delta) begin
            $error("raw_delta: expected %0d, got %0d", $signed(want.raw_delta),
                   out_raw_delta);
            fails++;
          end
          if (out_direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", $signed(want.direction),
                   out_direction);
            fails++;
          end
          if (out_scaled_count !== want.scaled_count) begin
            $error("scaled_count: expected %0h, got %0h", want.scaled_count,
                   out_scaled_count);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        tick.axis    = in_axis;
        tick.count   = in_encoder_count;
        tick.speed   = in_pulse_speed;
        tick.init    = in_init_request;
        tick.ref_vel = in_reference_velocity;
        expected_estimates.push_back(estimate_velocity(tick));
      end
    end
    pending    <= expected_estimates.size();
    fail_count <= fails;
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the encoder velocity estimator. Drives a directed
// set of ticks through every estimation path and its edge values, then
// several register settings with random ticks built around small count
// steps so that the pulse, hold and stop paths are reached. The sender
// runs in random bursts, the receiver stalls on its own pattern and once
// holds off long enough to back the block up. Checking is done by
// velocity_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int PHASE_ITEMS = 275;
  localparam int NUM_PHASES  = 6;
  localparam int IDLE_GAP    = 12;
  localparam int LONG_HOLD   = 300;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_DENSE
  } rx_mode_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_axis;
  logic        [31:0]                  in_encoder_count;
  logic signed [31:0]                  in_pulse_speed;
  logic                                in_init_request;
  logic signed [31:0]                  in_reference_velocity;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_axis_out;
  logic signed [31:0]                  out_velocity;
  logic signed [31:0]                  out_raw_delta;
  logic signed [1:0]                   out_direction;
  logic        [31:0]                  out_scaled_count;
  logic                                cfg_we;
  logic [enc_vel_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [enc_vel_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  int          pending;
  int          fail_count;
  int          burst_left;
  logic [31:0] last_count [2];
  logic        hold_off_req;
  logic        hold_off_done;
  rx_mode_t    rx_mode;

  encoder_velocity_estimator u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_axis               (in_axis),
    .in_encoder_count      (in_encoder_count),
    .in_pulse_speed        (in_pulse_speed),
    .in_init_request       (in_init_request),
    .in_reference_velocity (in_reference_velocity),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_axis_out          (out_axis_out),
    .out_velocity          (out_velocity),
    .out_raw_delta         (out_raw_delta),
    .out_direction         (out_direction),
    .out_scaled_count      (out_scaled_count),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  velocity_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_axis               (in_axis),
    .in_encoder_count      (in_encoder_count),
    .in_pulse_speed        (in_pulse_speed),
    .in_init_request       (in_init_request),
    .in_reference_velocity (in_reference_velocity),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_axis_out          (out_axis_out),
    .out_velocity          (out_velocity),
    .out_raw_delta         (out_raw_delta),
    .out_direction         (out_direction),
    .out_scaled_count      (out_scaled_count),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .pending               (pending),
    .fail_count            (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_tick(input logic ax, input logic [31:0] cnt, input logic [31:0] spd,
                           input logic init, input logic [31:0] rv);
    in_valid              <= 1'b1;
    in_axis               <= ax;
    in_encoder_count      <= cnt;
    in_pulse_speed        <= spd;
    in_init_request       <= init;
    in_reference_velocity <= rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    last_count[ax] = cnt;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [enc_vel_pkg::CFG_IDX_W-1:0] idx,
                           input logic [enc_vel_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic npt, input logic [1:0] mask,
                              input logic [4:0] s0, input logic [4:0] s1);
    write_reg(enc_vel_pkg::CFG_NO_PULSE_TIMER, {4'd0, npt});
    write_reg(enc_vel_pkg::CFG_SIM_AXIS_MASK, {3'd0, mask});
    write_reg(enc_vel_pkg::CFG_COUNT_SHIFT0, s0);
    write_reg(enc_vel_pkg::CFG_COUNT_SHIFT1, s1);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic random_tick;
    logic        ax;
    logic [31:0] cnt;
    logic [31:0] spd;
    logic [31:0] mag;
    logic [31:0] rv;
    int          pick;
    ax   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      cnt = last_count[ax] + $urandom_range(0, 12) - 32'd6;
    end else if (pick < 75) begin
      mag = $urandom_range(7, 40);
      cnt = $urandom_range(0, 1) ? last_count[ax] + mag : last_count[ax] - mag;
    end else if (pick < 85) begin
      cnt = last_count[ax];
    end else begin
      cnt = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      spd = $urandom_range(0, 256) - 32'd128;
    end else if (pick < 92) begin
      if (pick < 70) begin
        mag = $urandom_range(129, 4096);
      end else if (pick < 80) begin
        mag = $urandom_range(4097, 1 << 20);
      end else begin
        mag = $urandom;
      end
      spd = $urandom_range(0, 1) ? mag : (32'd0 - mag);
    end else begin
      case ($urandom_range(0, 5))
        0:       spd = 32'h8000_0000;
        1:       spd = 32'h7FFF_FFFF;
        2:       spd = 32'd128;
        3:       spd = 32'd0 - 32'd128;
        4:       spd = 32'd129;
        default: spd = 32'd0 - 32'd129;
      endcase
    end
    rv = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 600) - 32'd300);
    send_tick(ax, cnt, spd, $urandom_range(0, 9) == 0, rv);
  endtask

  initial begin
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_axis               <= 1'b0;
    in_encoder_count      <= 32'd0;
    in_pulse_speed        <= 32'sd0;
    in_init_request       <= 1'b0;
    in_reference_velocity <= 32'sd0;
    cfg_we                <= 1'b0;
    cfg_index             <= enc_vel_pkg::CFG_NO_PULSE_TIMER;
    cfg_wdata             <= '0;
    last_count[0]         = 32'd0;
    last_count[1]         = 32'd0;
    burst_left            = 0;
    hold_off_req          = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick(1'b0, 32'd0, 32'd0, 1'b0, 32'd5);
    send_tick(1'b0, 32'd7, 32'd0, 1'b0, 32'd0);
    send_tick(1'b0, 32'd1, 32'd0 - 32'd4096, 1'b0, 32'hFFFF_FFFF);
    send_tick(1'b0, 32'd1, 32'd0, 1'b0, 32'd0);
    send_tick(1'b0, 32'd1, 32'd100, 1'b0, 32'd0);
    send_tick(1'b0, 32'd1, 32'd0 - 32'd129, 1'b0, 32'd0);
    send_tick(1'b0, 32'd1, 32'd128, 1'b0, 32'd0);
    send_tick(1'b0, 32'd1, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF);
    send_tick(1'b0, 32'h1000_0001, 32'd0, 1'b0, 32'd0);
    send_tick(1'b0, 32'h9000_0001, 32'h7FFF_FFFF, 1'b0, 32'd0);
    send_tick(1'b0, 32'd0, 32'd0, 1'b1, 32'd0);
    send_tick(1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0);
    send_tick(1'b0, 32'd5, 32'd0, 1'b0, 32'd0);
    send_tick(1'b1, 32'hFFFF_FFFA, 32'h7FFF_FFFF, 1'b0, 32'd0);
    send_tick(1'b1, 32'hFFFF_FFF3, 32'd0, 1'b0, 32'd0);
    send_tick(1'b1, 32'hFFFF_FFF3, 32'd200, 1'b1, 32'd0);
    send_tick(1'b1, 32'hFFFF_FFF3, 32'd0, 1'b0, 32'd0);
    drain();

    apply_config(1'b1, 2'd0, 5'd31, 5'd1);
    send_tick(1'b0, 32'd5, 32'd5000, 1'b0, 32'd0);
    send_tick(1'b1, 32'hFFFF_FFF6, 32'd5000, 1'b0, 32'd0);
    drain();

    apply_config(1'b0, 2'd3, 5'd0, 5'd31);
    send_tick(1'b0, 32'd0, 32'd0, 1'b0, 32'h8000_0000);
    send_tick(1'b1, 32'hFFFF_FFFF, 32'd300, 1'b1, 32'h7FFF_FFFF);
    send_tick(1'b0, 32'd9, 32'd0, 1'b0, 32'd0 - 32'd15);
    send_tick(1'b1, 32'd0, 32'd0, 1'b0, 32'd0);
    send_tick(1'b0, 32'd3, 32'd0, 1'b0, 32'd16);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       apply_config(1'b0, 2'd0, 5'd0, 5'd0);
        1:       apply_config(1'b0, 2'd0, 5'd31, 5'd31);
        2:       apply_config(1'b1, 2'd0, 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)));
        3:       apply_config(1'b0, 2'd1, 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)));
        4:       apply_config(1'b0, 2'd2, 5'($urandom_range(0, 31)),
                              5'($urandom_range(0, 31)));
        default: apply_config(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                              5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
      endcase
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      repeat (PHASE_ITEMS) random_tick();
      drain();
    end

    repeat (IDLE_GAP) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    out_ready     <= 1'b0;
    hold_off_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        repeat ($urandom_range(8, 64)) begin
          case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

endmodule

/* files.f */
src/enc_vel_pkg.sv
src/encoder_velocity_estimator.sv
dv/velocity_checker.sv
dv/tb_top.sv
